// ===== rtl/qtcw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qtcw_pkg: shared types and constants of the quadratic turn curve walker
// Holds the step descriptor passed from front to back, the configuration
// register indexes, the queue depth and the sine table builder.
// ----------------------------------------------------------------------------
package qtcw_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP_LENGTH = 2'd0;
  localparam logic [1:0] CFG_TURN_STEP   = 2'd1;
  localparam logic [1:0] CFG_POINT_COUNT = 2'd2;

  // Register reset values
  localparam logic [23:0] STEP_LENGTH_RST = 24'd65536;
  localparam logic [31:0] TURN_STEP_RST   = 32'd0;
  localparam logic [15:0] POINT_COUNT_RST = 16'd1024;

  // Descriptor queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Two pi and Taylor series divisors (2n)(2n+1) for the sine table, Q30
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] TAYLOR_DIV [1:10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  // One point of the walk as classified by the front
  typedef struct packed {
    logic        restart;   // clear position before this point
    logic        last;      // last point of the run, no step afterwards
    logic [15:0] index;     // point index within the run
    logic [31:0] heading;   // heading of the step taken after this point
  } qtcw_desc_t;

  // Sine over the first quarter turn at table position r, rounded to
  // fbits fraction bits and capped at 1.0. Evaluated at elaboration only.
  function automatic logic [63:0] quarter_sine_f(input logic [31:0] r,
                                                 input int unsigned tbits,
                                                 input int unsigned fbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    x    = (64'(r) * TWO_PI_Q30) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = ($unsigned(sum) + (64'd1 << (29 - fbits))) >> (30 - fbits);
    if (v > (64'd1 << fbits)) begin
      v = 64'd1 << fbits;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qtcw_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qtcw_front: walk sequencer
// Accepts restart requests, decides whether the point ends the run and
// advances heading, heading increment and index once per transfer.
// ----------------------------------------------------------------------------
module qtcw_front
  import qtcw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        restart_i,
  input  wire logic        queue_full_i,
  input  wire logic [31:0] turn_step_i,
  input  wire logic [15:0] point_count_i,
  output logic             push_o,
  output qtcw_desc_t       desc_o
);

  logic [31:0] heading_q, heading_d;
  logic [31:0] incr_q, incr_d;
  logic [15:0] index_q, index_d;

  logic [31:0] base_heading;
  logic [31:0] base_incr;
  logic [15:0] base_index;
  logic [15:0] count_eff;
  logic        last;

  // Take an item whenever the queue has room
  assign push_o = in_valid_i && !queue_full_i;

  // Apply restart, then test for the end of the run
  always_comb begin
    base_heading = restart_i ? 32'd0 : heading_q;
    base_incr    = restart_i ? 32'd0 : incr_q;
    base_index   = restart_i ? 16'd0 : index_q;
    count_eff    = (point_count_i == 16'd0) ? 16'd1 : point_count_i;
    last         = ({1'b0, base_index} + 17'd1) >= {1'b0, count_eff};

    desc_o.restart = restart_i;
    desc_o.last    = last;
    desc_o.index   = base_index;
    desc_o.heading = base_heading + base_incr;

    if (last) begin
      heading_d = 32'd0;
      incr_d    = 32'd0;
      index_d   = 16'd0;
    end else begin
      heading_d = base_heading + base_incr;
      incr_d    = base_incr + turn_step_i;
      index_d   = base_index + 16'd1;
    end
  end

  // Advance the walk on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= 32'd0;
      incr_q    <= 32'd0;
      index_q   <= 16'd0;
    end else if (push_o) begin
      heading_q <= heading_d;
      incr_q    <= incr_d;
      index_q   <= index_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qtcw_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qtcw_queue: descriptor queue
// Short first-in first-out buffer that lets front and back stall apart.
// ----------------------------------------------------------------------------
module qtcw_queue
  import qtcw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire qtcw_desc_t push_desc_i,
  input  wire logic       pop_i,
  output logic            full_o,
  output logic            empty_o,
  output qtcw_desc_t      head_o
);

  qtcw_desc_t          entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q;
  logic [QUEUE_AW-1:0] rd_ptr_q;
  logic [QUEUE_AW:0]   fill_q;

  assign full_o  = (fill_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  // Store pushed descriptors
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qtcw_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qtcw_back: step datapath
// Looks up cosine and sine of the heading, scales them by the step length,
// rounds, accumulates the saturating position and holds the result.
// ----------------------------------------------------------------------------
module qtcw_back
  import qtcw_pkg::*;
#(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned SINE_FRAC_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [23:0] step_length_i,
  input  wire logic        queue_empty_i,
  input  wire qtcw_desc_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      x_position_o,
  output logic [31:0]      y_position_o,
  output logic [15:0]      point_index_o,
  output logic             last_point_o
);

  localparam int unsigned TB       = SINE_TABLE_BITS;
  localparam int unsigned TBL_SIZE = 1 << SINE_TABLE_BITS;
  localparam int unsigned QTR      = TBL_SIZE / 4;
  localparam int unsigned VAL_W    = SINE_FRAC_BITS + 2;
  localparam int unsigned PROD_W   = VAL_W + 25;
  localparam int unsigned DELTA_W  = PROD_W - SINE_FRAC_BITS;
  localparam int unsigned SUM_W    = 34;
  localparam int unsigned HALF     = 1 << (SINE_FRAC_BITS - 1);

  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(64'sd2147483648);

  // Sine table over one full turn
  logic signed [VAL_W-1:0] sine_tbl [TBL_SIZE];

  for (genvar k = 0; k < TBL_SIZE; k++) begin : g_tbl
    localparam int unsigned QUAD = k / QTR;
    localparam int unsigned POS  = k % QTR;
    localparam logic [63:0] MAG  = quarter_sine_f(
      ((QUAD % 2) == 1) ? 32'(QTR - POS) : 32'(POS), TB, SINE_FRAC_BITS);
    localparam logic signed [VAL_W-1:0] VAL =
      (QUAD >= 2) ? -$signed(VAL_W'(MAG)) : $signed(VAL_W'(MAG));
    assign sine_tbl[k] = VAL;
  end

  // Whole pipeline moves when the output register is free or draining
  logic adv;
  assign adv   = !out_valid_o || !out_stall_i;
  assign pop_o = adv && !queue_empty_i;

  // Table lookup stage
  logic                    v1_q, clr1_q, last1_q;
  logic [15:0]             idx1_q;
  logic signed [VAL_W-1:0] cos1_q, sin1_q;
  logic [TB-1:0]           sin_addr, cos_addr;

  assign sin_addr = head_i.heading[31 -: TB];
  assign cos_addr = sin_addr + TB'(QTR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= !queue_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      clr1_q  <= head_i.restart;
      last1_q <= head_i.last;
      idx1_q  <= head_i.index;
      cos1_q  <= sine_tbl[cos_addr];
      sin1_q  <= sine_tbl[sin_addr];
    end
  end

  // Scale stage: step length times cosine and sine
  logic                     v2_q, clr2_q, last2_q;
  logic [15:0]              idx2_q;
  logic signed [PROD_W-1:0] px2_q, py2_q;
  logic signed [24:0]       len_s;

  assign len_s = $signed({1'b0, step_length_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      clr2_q  <= clr1_q;
      last2_q <= last1_q;
      idx2_q  <= idx1_q;
      px2_q   <= len_s * cos1_q;
      py2_q   <= len_s * sin1_q;
    end
  end

  // Round stage: nearest, ties away from zero
  logic                      v3_q, clr3_q, last3_q;
  logic [15:0]               idx3_q;
  logic signed [DELTA_W-1:0] dx3_q, dy3_q;
  logic signed [PROD_W-1:0]  rx, ry;

  always_comb begin
    rx = px2_q + (px2_q[PROD_W-1] ? PROD_W'(HALF - 1) : PROD_W'(HALF));
    ry = py2_q + (py2_q[PROD_W-1] ? PROD_W'(HALF - 1) : PROD_W'(HALF));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      clr3_q  <= clr2_q;
      last3_q <= last2_q;
      idx3_q  <= idx2_q;
      dx3_q   <= DELTA_W'(rx >>> SINE_FRAC_BITS);
      dy3_q   <= DELTA_W'(ry >>> SINE_FRAC_BITS);
    end
  end

  // Accumulate stage: emit current position, then step with saturation
  logic signed [31:0]      x_acc_q, x_acc_d, y_acc_q, y_acc_d;
  logic signed [31:0]      x_cur, y_cur;
  logic signed [SUM_W-1:0] x_sum, y_sum;

  always_comb begin
    x_cur = clr3_q ? 32'sd0 : x_acc_q;
    y_cur = clr3_q ? 32'sd0 : y_acc_q;
    x_sum = SUM_W'(x_cur) + SUM_W'(dx3_q);
    y_sum = SUM_W'(y_cur) + SUM_W'(dy3_q);
    if (last3_q) begin
      x_acc_d = 32'sd0;
    end else if (x_sum > POS_MAX) begin
      x_acc_d = 32'(POS_MAX);
    end else if (x_sum < POS_MIN) begin
      x_acc_d = 32'(POS_MIN);
    end else begin
      x_acc_d = 32'(x_sum);
    end
    if (last3_q) begin
      y_acc_d = 32'sd0;
    end else if (y_sum > POS_MAX) begin
      y_acc_d = 32'(POS_MAX);
    end else if (y_sum < POS_MIN) begin
      y_acc_d = 32'(POS_MIN);
    end else begin
      y_acc_d = 32'(y_sum);
    end
  end

  logic out_v_q;
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_acc_q <= 32'sd0;
      y_acc_q <= 32'sd0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v3_q;
      if (v3_q) begin
        x_acc_q <= x_acc_d;
        y_acc_q <= y_acc_d;
      end
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk_i) begin
    if (adv && v3_q) begin
      x_position_o  <= x_cur;
      y_position_o  <= y_cur;
      point_index_o <= idx3_q;
      last_point_o  <= last3_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/quadratic_turn_curve_walker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_turn_curve_walker: turtle walk along a discrete Euler spiral
// Emits one Q16.16 point per input item and advances a heading whose
// increment grows by a programmable turn step at every point.
// ----------------------------------------------------------------------------
// Rate: one item per clock cycle sustained while the output is not stalled. An
// accepted item passes a registered heading recurrence in the front, which
// writes a four-entry descriptor queue, and the back runs sine table
// read, step length multiply, rounding and saturating accumulate as four
// registered stages. The queue absorbs output stalls, so input is taken until
// four descriptors wait. Write configuration only while no result is pending.
// ----------------------------------------------------------------------------
module quadratic_turn_curve_walker
  import qtcw_pkg::*;
#(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned SINE_FRAC_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        restart_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      x_position_o,
  output logic [31:0]      y_position_o,
  output logic [15:0]      point_index_o,
  output logic             last_point_o
);

  logic [23:0] step_length_q;
  logic [31:0] turn_step_q;
  logic [15:0] point_count_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_length_q <= STEP_LENGTH_RST;
      turn_step_q   <= TURN_STEP_RST;
      point_count_q <= POINT_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STEP_LENGTH: step_length_q <= cfg_data_i[23:0];
        CFG_TURN_STEP:   turn_step_q   <= cfg_data_i;
        CFG_POINT_COUNT: point_count_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  qtcw_desc_t push_desc;
  qtcw_desc_t head_desc;

  assign in_stall_o = q_full;

  qtcw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .restart_i     (restart_i),
    .queue_full_i  (q_full),
    .turn_step_i   (turn_step_q),
    .point_count_i (point_count_q),
    .push_o        (push),
    .desc_o        (push_desc)
  );

  qtcw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head_desc)
  );

  qtcw_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SINE_FRAC_BITS  (SINE_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_length_i (step_length_q),
    .queue_empty_i (q_empty),
    .head_i        (head_desc),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .x_position_o  (x_position_o),
    .y_position_o  (y_position_o),
    .point_index_o (point_index_o),
    .last_point_o  (last_point_o)
  );

endmodule
`default_nettype wire

// ===== test/quadratic_turn_curve_walker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_turn_curve_walker_tb: self-checking bench for the spiral walker
// A queue-fed driver and a clocked monitor run restart items through the block
// under random input gaps and output stalls. A local walk model predicts every
// point. Settings change between drained phases: extremes, straight
// saturating legs and point counts lowered in the middle of a run.
// ----------------------------------------------------------------------------
module quadratic_turn_curve_walker_tb;

  localparam int unsigned    LUT_BITS   = 10;
  localparam int unsigned    FRAC_BITS  = 16;
  localparam int unsigned    LUT_SIZE   = 1 << LUT_BITS;
  localparam int unsigned    LUT_QTR    = LUT_SIZE >> 2;
  localparam longint unsigned PI2_Q30   = 64'd6746518852;
  localparam int unsigned    ITEM_GOAL  = 1900;
  localparam int unsigned    HANG_LIMIT = 2000;
  localparam int unsigned    DRAIN_WAIT = 6;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        index;
    logic               last;
  } point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] x_position_o;
  logic [31:0] y_position_o;
  logic [15:0] point_index_o;
  logic        last_point_o;

  // walk model: settings and state
  logic [23:0]        cfg_step_len;
  logic [31:0]        cfg_turn_step;
  logic [15:0]        cfg_point_count;
  logic [31:0]        walk_heading;
  logic [31:0]        walk_turn_rate;
  logic signed [31:0] walk_x;
  logic signed [31:0] walk_y;
  logic [15:0]        walk_index;
  logic signed [31:0] sine_lut [0:LUT_SIZE-1];

  logic   pending_restarts [$];
  point_t expected_points [$];
  int unsigned gap_pct = 22;
  int unsigned calm_start = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  int unsigned points_checked = 0;
  int unsigned restarts_seen = 0;
  int unsigned run_ends_seen = 0;
  int unsigned limit_hits = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  quadratic_turn_curve_walker uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .x_position_o (x_position_o),
    .y_position_o (y_position_o),
    .point_index_o(point_index_o),
    .last_point_o (last_point_o)
  );

  always #5 clk_i = ~clk_i;

  // Sine over the first quarter turn: truncated Taylor terms in Q30,
  // rounded half up to the table precision and capped at one
  function automatic longint quarter_wave(input int unsigned r);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned divisor;
    longint unsigned rounded;
    longint          acc;
    ang    = r;
    ang    = (ang * PI2_Q30) >> LUT_BITS;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = longint'(ang);
    for (int n = 1; n <= 10; n++) begin
      divisor = (2 * n) * (2 * n + 1);
      term    = ((term * ang_sq) >> 30) / divisor;
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = acc;
    rounded = (rounded + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (rounded > (64'd1 << FRAC_BITS)) begin
      rounded = 64'd1 << FRAC_BITS;
    end
    return longint'(rounded);
  endfunction

  // Step length times a table value, rounded to Q16.16, ties away from zero
  function automatic longint step_delta(input logic signed [31:0] trig);
    longint prod;
    longint mag;
    prod = longint'(cfg_step_len) * longint'(trig);
    mag  = (prod < 0) ? -prod : prod;
    mag  = (mag + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return (prod < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [31:0] clamp_add(input logic signed [31:0] acc,
                                                   input longint delta);
    longint total;
    total = longint'(acc) + delta;
    if (total > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (total < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return total[31:0];
  endfunction

  function automatic void clear_walk();
    walk_heading   = '0;
    walk_turn_rate = '0;
    walk_x         = '0;
    walk_y         = '0;
    walk_index     = '0;
  endfunction

  // Emit the current point, then take one step of the walk
  function automatic point_t next_point(input logic restart);
    point_t      pt;
    int unsigned count;
    logic [9:0]  sin_ang;
    logic [9:0]  cos_ang;
    count = (cfg_point_count == 0) ? 1 : cfg_point_count;
    if (restart) begin
      clear_walk();
    end
    pt.x     = walk_x;
    pt.y     = walk_y;
    pt.index = walk_index;
    pt.last  = (int'(walk_index) + 1) >= count;
    if (pt.last) begin
      clear_walk();
    end else begin
      walk_heading   = walk_heading + walk_turn_rate;
      walk_turn_rate = walk_turn_rate + cfg_turn_step;
      sin_ang        = walk_heading[31:32-LUT_BITS];
      cos_ang        = sin_ang + 10'(LUT_QTR);
      walk_x         = clamp_add(walk_x, step_delta(sine_lut[cos_ang]));
      walk_y         = clamp_add(walk_y, step_delta(sine_lut[sin_ang]));
      walk_index     = walk_index + 16'd1;
    end
    return pt;
  endfunction

  // Driver: offer the next pending item once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_restarts.size() > 0 && $urandom_range(99) >= gap_pct) begin
        in_valid_i <= 1'b1;
        restart_i  <= pending_restarts.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < gap_pct);
    end
  end

  // Monitor: check each output transfer, predict each input transfer
  always @(posedge clk_i) begin
    point_t want;
    logic   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_points.size() == 0) begin
          $display("%0t: point with no prediction: x=%h y=%h index=%0d last=%b",
                   $time, x_position_o, y_position_o, point_index_o, last_point_o);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          points_checked++;
          if (x_position_o !== want.x) begin
            $display("%0t: x_position expected %h actual %h", $time, want.x, x_position_o);
            mismatches++;
          end
          if (y_position_o !== want.y) begin
            $display("%0t: y_position expected %h actual %h", $time, want.y, y_position_o);
            mismatches++;
          end
          if (point_index_o !== want.index) begin
            $display("%0t: point_index expected %0d actual %0d",
                     $time, want.index, point_index_o);
            mismatches++;
          end
          if (last_point_o !== want.last) begin
            $display("%0t: last_point expected %b actual %b", $time, want.last, last_point_o);
            mismatches++;
          end
          if (want.last) begin
            run_ends_seen++;
          end
          if (want.x == 32'sh7FFF_FFFF || want.x == 32'sh8000_0000 ||
              want.y == 32'sh7FFF_FFFF || want.y == 32'sh8000_0000) begin
            limit_hits++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        if (restart_i) begin
          restarts_seen++;
        end
        expected_points.push_back(next_point(restart_i));
      end
      // watchdog: give up when nothing moves for too long
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Wait until no item is pending and every point has come out
  task automatic wait_drained();
    while (pending_restarts.size() > 0 || in_valid_i || expected_points.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // Program all three registers while the block is drained
  task automatic apply_cfg(input logic [23:0] step_len, input logic [31:0] turn,
                           input logic [15:0] count);
    wait_drained();
    cfg_step_len    = step_len;
    cfg_turn_step   = turn;
    cfg_point_count = count;
    settings_used++;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= qtcw_pkg::CFG_STEP_LENGTH;
    cfg_data_i  <= {8'd0, step_len};
    @(posedge clk_i);
    cfg_index_i <= qtcw_pkg::CFG_TURN_STEP;
    cfg_data_i  <= turn;
    @(posedge clk_i);
    cfg_index_i <= qtcw_pkg::CFG_POINT_COUNT;
    cfg_data_i  <= {16'd0, count};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_items(input int unsigned n, input int unsigned restart_pct,
                             input logic first_restart);
    @(negedge clk_i);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0) begin
        pending_restarts.push_back(first_restart);
      end else begin
        pending_restarts.push_back($urandom_range(99) < restart_pct);
      end
    end
    items_sent += n;
  endtask

  function automatic logic [23:0] pick_step_len();
    case ($urandom_range(5))
      0:       return 24'd0;
      1:       return 24'hFF_FFFF;
      2:       return 24'($urandom_range(32'h2_0000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_turn();
    case ($urandom_range(6))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(3)) << 30;
      3:       return 32'($urandom_range(32'h10_0000));
      4:       return -32'($urandom_range(32'h10_0000));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(6))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd2;
      3:       return 16'hFFFF;
      4:       return 16'($urandom);
      default: return 16'($urandom_range(3, 40));
    endcase
  endfunction

  // Stimulus
  initial begin
    int unsigned  q;
    int unsigned  r;
    longint       s;
    int unsigned  kind;
    int unsigned  n1;
    logic [23:0]  step_len;
    logic [31:0]  turn;
    logic [31:0]  steer;
    logic         first_phase;

    // sine table over one turn, built from the first quarter by symmetry
    for (int unsigned k = 0; k < LUT_SIZE; k++) begin
      q = k / LUT_QTR;
      r = k % LUT_QTR;
      s = (q % 2 == 1) ? quarter_wave(LUT_QTR - r) : quarter_wave(r);
      sine_lut[k] = (q >= 2) ? -s[31:0] : s[31:0];
    end
    cfg_step_len    = qtcw_pkg::STEP_LENGTH_RST;
    cfg_turn_step   = qtcw_pkg::TURN_STEP_RST;
    cfg_point_count = qtcw_pkg::POINT_COUNT_RST;
    clear_walk();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, zero and one point counts, extreme steps,
    // then the count lowered below the current index
    queue_items(4, 50, 1'b0);
    apply_cfg(24'd0, 32'd0, 16'd0);
    queue_items(3, 50, 1'b1);
    apply_cfg(24'hFF_FFFF, 32'hFFFF_FFFF, 16'd1);
    queue_items(3, 50, 1'b0);
    apply_cfg(24'hFF_FFFF, 32'h0000_0001, 16'd2);
    queue_items(4, 0, 1'b1);
    apply_cfg(24'h00_8000, 32'h4000_0000, 16'hFFFF);
    queue_items(6, 20, 1'b1);
    apply_cfg(24'h00_8000, 32'h4000_0000, 16'd3);
    queue_items(3, 0, 1'b0);

    // random phases
    first_phase = 1'b1;
    while (items_sent < ITEM_GOAL) begin
      // one stretch of at least 300 items with no random idling
      if (calm_start == 0 && items_sent >= 800) begin
        calm_start = items_sent;
      end
      gap_pct = (calm_start != 0 && items_sent < calm_start + 300) ? 0 : 22;
      kind    = first_phase ? 6 : $urandom_range(9);
      first_phase = 1'b0;
      if (kind <= 5) begin
        apply_cfg(pick_step_len(), pick_turn(), pick_count());
        queue_items($urandom_range(10, 80), 4, $urandom_range(1));
      end else if (kind <= 7) begin
        // straight legs in quarter-turn directions: rotate by steer, then
        // cancel the rate again so the heading holds and the position clips
        step_len = 24'($urandom_range(24'hC0_0000, 24'hFF_FFFF));
        for (int leg = 0; leg < 3; leg++) begin
          steer = 32'($urandom_range(3)) << 30;
          apply_cfg(step_len, steer, 16'hFFFF);
          queue_items(1, 0, leg == 0);
          apply_cfg(step_len, -steer, 16'hFFFF);
          queue_items(1, 0, 1'b0);
          apply_cfg(step_len, 32'd0, 16'hFFFF);
          queue_items($urandom_range(60, 200), 0, 1'b0);
        end
      end else begin
        // lower the point count mid-run to at most one above the current index
        step_len = pick_step_len();
        turn     = pick_turn();
        n1       = $urandom_range(5, 40);
        apply_cfg(step_len, turn, 16'hFFFF);
        queue_items(n1, 0, 1'b1);
        apply_cfg(step_len, turn, 16'($urandom_range(0, n1 + 1)));
        queue_items($urandom_range(5, 30), 4, 1'b0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d points over %0d register settings: %0d restarts, %0d run ends,",
             points_checked, settings_used, restarts_seen, run_ends_seen);
    $display("%0d points at a position limit, %0d field mismatches.", limit_hits, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/qtcw_pkg.sv
rtl/qtcw_front.sv
rtl/qtcw_queue.sv
rtl/qtcw_back.sv
rtl/quadratic_turn_curve_walker.sv
test/quadratic_turn_curve_walker_tb.sv
